@@ hdl/tca_pkg.sv @@
`default_nettype none

package tca_pkg;

  // Side format.
  localparam int SIDE_WIDTH     = 16;
  localparam int SIDE_FRAC_BITS = 8;

  // Result format: unsigned Q15.16 area, saturated to 31 bits.
  localparam int AREA_W = 31;
  localparam int RAD_W  = 2 * AREA_W;
  localparam int REM_W  = AREA_W + 3;

  // Heron term widths. The perimeter needs two extra bits. Each difference
  // needs one, because for a triangle it is positive and below the sum of two sides.
  localparam int SUM_W  = SIDE_WIDTH + 2;
  localparam int DIF_W  = SIDE_WIDTH + 1;
  localparam int PRD1_W = SUM_W + DIF_W;
  localparam int PRD2_W = 2 * DIF_W;
  localparam int LO_W   = PRD2_W / 2;
  localparam int HI_W   = PRD2_W - LO_W;
  localparam int PROD_W = PRD1_W + PRD2_W;

  // The product is scaled by 2^(32 - 4*frac) / 16. The left shift is applied
  // first, so the bits shifted out on the right are simply dropped.
  localparam int SHIFT_UP = 28;
  localparam int SHIFT_DN = 4 * SIDE_FRAC_BITS;
  localparam int SCL_W    = PROD_W + SHIFT_UP;

  typedef enum logic [1:0] {
    KIND_EQUILATERAL = 2'd0,
    KIND_ISOSCELES   = 2'd1,
    KIND_SCALENE     = 2'd2,
    KIND_NONE        = 2'd3
  } tca_kind_e;

  // Flags that travel along with an item.
  typedef struct packed {
    logic      is_tri;
    tca_kind_e kind;
  } tca_flag_t;

  // Contents of one square-root cell.
  typedef struct packed {
    tca_flag_t          flag;
    logic               sat;
    logic [RAD_W-1:0]   rad;
    logic [REM_W-1:0]   rem;
    logic [AREA_W-1:0]  root;
  } tca_cell_t;

endpackage

`default_nettype wire

@@ hdl/tca_side_if.sv @@
`default_nettype none

interface tca_side_if
  import tca_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [SIDE_WIDTH-1:0] side_a;
  logic [SIDE_WIDTH-1:0] side_b;
  logic [SIDE_WIDTH-1:0] side_c;

  modport source (output valid, output side_a, output side_b, output side_c, input ready);
  modport sink (input valid, input side_a, input side_b, input side_c, output ready);
endinterface

`default_nettype wire

@@ hdl/tca_area_if.sv @@
`default_nettype none

interface tca_area_if
  import tca_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              is_triangle;
  logic [1:0]        kind;
  logic [AREA_W-1:0] area;

  modport source (output valid, output is_triangle, output kind, output area, input ready);
  modport sink (input valid, input is_triangle, input kind, input area, output ready);
endinterface

`default_nettype wire

@@ hdl/triangle_check_classify_area.sv @@
// Channel   Direction  Transaction contents
// side_i    in         side_a, side_b, side_c: unsigned Q8.8 side lengths
// res_o     out        is_triangle, kind, area (unsigned Q15.16, rounded down)
//
// An accepted input transaction passes through four front-end stages, one cell
// per root bit (31 cells), and the output register before its result appears.
// One transaction is accepted per cycle while the receiver takes the results.
// Every stage and cell has its own valid bit and takes new data whenever it
// is empty or its successor moves, so bubbles close up under a stall.
// Reset clears only the valid bits; no state survives between transactions.
`default_nettype none

module triangle_check_classify_area
  import tca_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tca_side_if.sink   side_i,
  tca_area_if.source res_o
);

  localparam int NCELL = AREA_W;

  // Element 0 is the front end output; element k is the output of cell k.
  logic      chain_valid [0:NCELL];
  logic      chain_ready [0:NCELL];
  tca_cell_t chain_data  [0:NCELL];

  logic              out_valid_q;
  logic              out_load;
  logic              out_tri_q;
  tca_kind_e         out_kind_q;
  logic [AREA_W-1:0] out_area_d, out_area_q;
  tca_cell_t         last;

  // Front end: inequality test, classification and the scaled Heron product.
  tca_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (side_i.valid),
    .up_ready_o (side_i.ready),
    .side_a_i   (side_i.side_a),
    .side_b_i   (side_i.side_b),
    .side_c_i   (side_i.side_c),
    .dn_valid_o (chain_valid[0]),
    .dn_ready_i (chain_ready[0]),
    .dn_data_o  (chain_data[0])
  );

  // Square-root chain: each cell settles one root bit, most significant first,
  // and hands the partial remainder and root to its neighbor.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    tca_sqrt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (chain_valid[k]),
      .up_ready_o (chain_ready[k]),
      .up_data_i  (chain_data[k]),
      .dn_valid_o (chain_valid[k+1]),
      .dn_ready_i (chain_ready[k+1]),
      .dn_data_o  (chain_data[k+1])
    );
  end

  // The output register takes a result whenever it is empty or being drained.
  assign out_load           = ~out_valid_q | res_o.ready;
  assign chain_ready[NCELL] = out_load;
  assign last               = chain_data[NCELL];

  // Not a triangle forces a zero area; a radicand beyond 62 bits saturates.
  always_comb begin
    if (!last.flag.is_tri) begin
      out_area_d = '0;
    end else if (last.sat) begin
      out_area_d = '1;
    end else begin
      out_area_d = last.root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= chain_valid[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && chain_valid[NCELL]) begin
      out_tri_q  <= last.flag.is_tri;
      out_kind_q <= last.flag.kind;
      out_area_q <= out_area_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.is_triangle = out_tri_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.area        = out_area_q;

`ifndef SYNTHESIS
  // A rejected triangle always reports the "none" kind and a zero area.
  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.is_triangle) |-> (res_o.kind == KIND_NONE && res_o.area == '0))
    else $error("rejected triangle with nonzero area or wrong kind");

  // An accepted triangle never carries the "none" kind.
  a_tri_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.is_triangle) |-> (res_o.kind != KIND_NONE))
    else $error("valid triangle reported with kind none");

  // A finished root held back by a full output register stays in the last cell.
  a_chain_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid[NCELL] && !out_load) |=> (chain_valid[NCELL] && $stable(last)))
    else $error("root chain dropped or changed a stalled result");
`endif

endmodule

`default_nettype wire

@@ hdl/tca_front.sv @@
`default_nettype none

// Four stage front end: inequality test and kind, Heron terms, two
// partial-product stages, then the scaled radicand for the root chain.
module tca_front
  import tca_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  up_valid_i,
  output logic                       up_ready_o,
  input  wire logic [SIDE_WIDTH-1:0] side_a_i,
  input  wire logic [SIDE_WIDTH-1:0] side_b_i,
  input  wire logic [SIDE_WIDTH-1:0] side_c_i,
  output logic                       dn_valid_o,
  input  wire logic                  dn_ready_i,
  output tca_cell_t                  dn_data_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  tca_flag_t          flag1_d, flag1_q, flag2_q, flag3_q;
  logic [SUM_W-1:0]   sum_d, sum_q;
  logic [DIF_W-1:0]   dif1_d, dif2_d, dif3_d, dif1_q, dif2_q, dif3_q;
  logic [PRD1_W-1:0]  p1_d, p1_q;
  logic [PRD2_W-1:0]  p2_d, p2_q;
  logic [PRD1_W+LO_W-1:0] pl_d, pl_q;
  logic [PRD1_W+HI_W-1:0] ph_d, ph_q;
  logic [PROD_W-1:0]  prod;
  logic [SCL_W-1:0]   scaled;
  tca_cell_t          c4_d, c4_q;
  logic               eq_ab, eq_ac, eq_bc;

  assign rdy4       = ~v4_q | dn_ready_i;
  assign rdy3       = ~v3_q | rdy4;
  assign rdy2       = ~v2_q | rdy3;
  assign rdy1       = ~v1_q | rdy2;
  assign up_ready_o = rdy1;
  assign dn_valid_o = v4_q;
  assign dn_data_o  = c4_q;

  // Stage 1: strict inequalities, kind and the four Heron terms.
  always_comb begin
    eq_ab = (side_a_i == side_b_i);
    eq_ac = (side_a_i == side_c_i);
    eq_bc = (side_b_i == side_c_i);
    flag1_d.is_tri = ({1'b0, side_a_i} + {1'b0, side_b_i} > {1'b0, side_c_i}) &&
                     ({1'b0, side_a_i} + {1'b0, side_c_i} > {1'b0, side_b_i}) &&
                     ({1'b0, side_b_i} + {1'b0, side_c_i} > {1'b0, side_a_i});
    if (!flag1_d.is_tri) begin
      flag1_d.kind = KIND_NONE;
    end else if (eq_ab && eq_ac) begin
      flag1_d.kind = KIND_EQUILATERAL;
    end else if (eq_ab || eq_ac || eq_bc) begin
      flag1_d.kind = KIND_ISOSCELES;
    end else begin
      flag1_d.kind = KIND_SCALENE;
    end
    sum_d  = SUM_W'(side_a_i) + SUM_W'(side_b_i) + SUM_W'(side_c_i);
    dif1_d = DIF_W'({1'b0, side_b_i} + {1'b0, side_c_i} - {1'b0, side_a_i});
    dif2_d = DIF_W'({1'b0, side_a_i} + {1'b0, side_c_i} - {1'b0, side_b_i});
    dif3_d = DIF_W'({1'b0, side_a_i} + {1'b0, side_b_i} - {1'b0, side_c_i});
  end

  // Stage 2: two narrow products. Stage 3: the wide product is split on
  // the second factor into two partial products.
  always_comb begin
    p1_d = PRD1_W'(sum_q) * PRD1_W'(dif1_q);
    p2_d = PRD2_W'(dif2_q) * PRD2_W'(dif3_q);
    pl_d = (PRD1_W+LO_W)'(p1_q) * (PRD1_W+LO_W)'(p2_q[LO_W-1:0]);
    ph_d = (PRD1_W+HI_W)'(p1_q) * (PRD1_W+HI_W)'(p2_q[PRD2_W-1:LO_W]);
  end

  // Stage 4: recombine, scale, and flag radicands that exceed the root range.
  always_comb begin
    prod   = PROD_W'(pl_q) + (PROD_W'(ph_q) << LO_W);
    scaled = (SCL_W'(prod) << SHIFT_UP) >> SHIFT_DN;
    c4_d.flag = flag3_q;
    c4_d.sat  = |scaled[SCL_W-1:RAD_W];
    c4_d.rad  = scaled[RAD_W-1:0];
    c4_d.rem  = '0;
    c4_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= up_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && up_valid_i) begin
      flag1_q <= flag1_d;
      sum_q   <= sum_d;
      dif1_q  <= dif1_d;
      dif2_q  <= dif2_d;
      dif3_q  <= dif3_d;
    end
    if (rdy2 && v1_q) begin
      flag2_q <= flag1_q;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
    end
    if (rdy3 && v2_q) begin
      flag3_q <= flag2_q;
      pl_q    <= pl_d;
      ph_q    <= ph_d;
    end
    if (rdy4 && v3_q) begin
      c4_q <= c4_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tca_sqrt_cell.sv @@
`default_nettype none

// One restoring square-root step: brings down the next two radicand bits
// and decides one root bit.
module tca_sqrt_cell
  import tca_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      up_valid_i,
  output logic           up_ready_o,
  input  wire tca_cell_t up_data_i,
  output logic           dn_valid_o,
  input  wire logic      dn_ready_i,
  output tca_cell_t      dn_data_o
);

  logic             valid_q;
  tca_cell_t        data_d, data_q;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;

  assign up_ready_o = ~valid_q | dn_ready_i;
  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

  always_comb begin
    rem_sh = {up_data_i.rem[REM_W-3:0], up_data_i.rad[RAD_W-1:RAD_W-2]};
    trial  = {1'b0, up_data_i.root, 2'b01};
    take   = (rem_sh >= trial);
    data_d      = up_data_i;
    data_d.rad  = {up_data_i.rad[RAD_W-3:0], 2'b00};
    data_d.rem  = take ? (rem_sh - trial) : rem_sh;
    data_d.root = {up_data_i.root[AREA_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_triangle_check_classify_area.sv @@
`timescale 1ns / 1ps

module tb_triangle_check_classify_area;
  import tca_pkg::*;

  // The pipeline is 36 stages deep; the drain wait is long enough to cover anything in flight.
  localparam int DRAIN_CYCLES = 80;
  // The receiver's long hold-off. It is far longer than the pipeline, so the
  // block fills up completely and has to stall its input.
  localparam int HOLD_CYCLES = 300;
  // This leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 340;
  localparam int PRESSURE_ITEMS = 110;

  typedef logic [SIDE_WIDTH-1:0] side_t;

  // The result of one transaction on the output channel.
  typedef struct packed {
    logic              is_tri;
    tca_kind_e         kind;
    logic [AREA_W-1:0] area;
  } tri_result_t;

  // One expected result, together with the sides that caused it, for reporting.
  typedef struct packed {
    side_t       a;
    side_t       b;
    side_t       c;
    tri_result_t res;
  } tri_expect_t;

  // The scoreboard predicts each triangle as its sides are accepted and checks the
  // results in order. The block keeps no state, so each prediction stands alone.
  class tri_scoreboard;
    tri_expect_t pending[$];
    int          failures;

    function new();
      failures = 0;
    endfunction

    function void flag_mismatch(string what);
      failures++;
      if (failures <= 10) $display("mismatch: %s", what);
    endfunction

    // Strict triangle test, kind and Heron area. With the raw sides A, B, C the
    // area is floor(sqrt(P * 2^(28 - 4*frac))), which saturates at 2^31-1.
    function tri_result_t classify_triangle(side_t a, side_t b, side_t c);
      tri_result_t r;
      logic [127:0] wa, wb, wc;
      logic [127:0] heron_prod;
      logic [127:0] scaled;
      logic [63:0]  root, trial;
      int           shift;
      int           bit_idx;
      wa = 128'(a);
      wb = 128'(b);
      wc = 128'(c);
      r.is_tri = 1'b0;
      r.kind = KIND_NONE;
      r.area = '0;
      if ((wa + wb > wc) && (wa + wc > wb) && (wb + wc > wa)) begin
        r.is_tri = 1'b1;
        if (a == b && a == c) begin
          r.kind = KIND_EQUILATERAL;
        end else if (a == b || a == c || b == c) begin
          r.kind = KIND_ISOSCELES;
        end else begin
          r.kind = KIND_SCALENE;
        end
        heron_prod = (wa + wb + wc) * (wb + wc - wa) * (wa + wc - wb) * (wa + wb - wc);
        shift = 28 - 4 * SIDE_FRAC_BITS;
        if (shift >= 0) begin
          scaled = heron_prod << shift;
        end else begin
          scaled = heron_prod >> (-shift);
        end
        if (scaled >= (128'd1 << 62)) begin
          r.area = '1;
        end else begin
          root = '0;
          for (bit_idx = 30; bit_idx >= 0; bit_idx--) begin
            trial = root | (64'd1 << bit_idx);
            if (trial * trial <= scaled[63:0]) root = trial;
          end
          r.area = root[AREA_W-1:0];
        end
      end
      return r;
    endfunction

    function void note_sides(side_t a, side_t b, side_t c);
      tri_expect_t e;
      e.a = a;
      e.b = b;
      e.c = c;
      e.res = classify_triangle(a, b, c);
      pending.push_back(e);
    endfunction

    function void check_result(logic is_tri, logic [1:0] kind, logic [AREA_W-1:0] area);
      tri_expect_t e;
      string       sides;
      if (pending.size() == 0) begin
        flag_mismatch($sformatf("unexpected result is_triangle=%0b kind=%0d area=%0d",
                                is_tri, kind, area));
        return;
      end
      e = pending.pop_front();
      sides = $sformatf("sides %0d,%0d,%0d", e.a, e.b, e.c);
      if (is_tri !== e.res.is_tri)
        flag_mismatch($sformatf("%s is_triangle expected %0b got %0b",
                                sides, e.res.is_tri, is_tri));
      if (kind !== e.res.kind)
        flag_mismatch($sformatf("%s kind expected %0d got %0d", sides, e.res.kind, kind));
      if (area !== e.res.area)
        flag_mismatch($sformatf("%s area expected %0d got %0d", sides, e.res.area, area));
    endfunction

    // Anything still waiting here never came out of the block.
    function void close_out();
      if (pending.size() != 0) begin
        failures += pending.size();
        $display("mismatch: %0d expected results never arrived", pending.size());
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tca_side_if side_if ();
  tca_area_if res_if ();

  triangle_check_classify_area DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  tri_scoreboard board;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  // The main process changes them from phase to phase.
  int send_idle_pct = 0;
  int stall_pct = 0;
  // Each increment asks the receiver for one long hold-off.
  int hold_requests = 0;
  int cycle_count = 0;

  // Watchdog. A correct run ends long before this.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Both channels are observed at the clock edge, so what is seen here is the
  // value that was present when the edge came. Every input transaction gets its
  // prediction, every output transaction is checked against the oldest one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (side_if.valid && side_if.ready)
        board.note_sides(side_if.side_a, side_if.side_b, side_if.side_c);
      if (res_if.valid && res_if.ready)
        board.check_result(res_if.is_triangle, res_if.kind, res_if.area);
    end
  end

  // Result receiver. It stalls at random, and on request it holds ready low for
  // a long stretch that it counts itself.
  initial begin : result_sink
    int hold_left;
    int holds_done;
    hold_left = 0;
    holds_done = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one triangle and returns at the edge where the transaction is taken.
  // Idle cycles come before the offer, so valid never drops while it waits.
  task automatic send_sides(input side_t a, input side_t b, input side_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      side_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    side_if.valid <= 1'b1;
    side_if.side_a <= a;
    side_if.side_b <= b;
    side_if.side_c <= c;
    @(posedge clk_i);
    while (!side_if.ready) @(posedge clk_i);
  endtask

  // Random triangle. Most of the draws are shaped: near-degenerate sides, equal
  // pairs and triples, tiny sides with zeros, and sides close to full scale.
  // Fully random sides cover every bit of every field and make about half of
  // the draws valid triangles.
  task automatic send_random_triangle();
    side_t x, y, z;
    int    mode;
    int    sum;
    mode = $urandom_range(99);
    x = side_t'($urandom_range(65535));
    y = side_t'($urandom_range(65535));
    z = side_t'($urandom_range(65535));
    if (mode < 30) begin
      // Sides are already fully random.
    end else if (mode < 50) begin
      x = side_t'($urandom_range(32767));
      y = side_t'($urandom_range(32767));
      sum = int'(x) + int'(y) + $urandom_range(2) - 1;
      if (sum < 0) sum = 0;
      z = side_t'(sum);
    end else if (mode < 65) begin
      y = x;
    end else if (mode < 70) begin
      y = x;
      z = x;
    end else if (mode < 85) begin
      x = side_t'($urandom_range(7));
      y = side_t'($urandom_range(7));
      z = side_t'($urandom_range(7));
    end else begin
      x = 16'hFFFF - side_t'($urandom_range(255));
      y = 16'hFFFF - side_t'($urandom_range(255));
      z = 16'hFFFF - side_t'($urandom_range(255));
    end
    // Rotate so that the odd side lands in every position.
    case ($urandom_range(2))
      0: send_sides(x, y, z);
      1: send_sides(y, z, x);
      default: send_sides(z, x, y);
    endcase
  endtask

  initial begin : stimulus
    int phase;
    int n;
    board = new();
    rst_ni <= 1'b0;
    side_if.valid <= 1'b0;
    side_if.side_a <= '0;
    side_if.side_b <= '0;
    side_if.side_c <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases: zero sides, degenerate triangles that just miss the strict
    // inequality, each kind, and the extremes of the side range.
    send_sides(16'd0, 16'd0, 16'd0);
    send_sides(16'd0, 16'd5, 16'd5);
    send_sides(16'd7, 16'd0, 16'd7);
    send_sides(16'hFFFF, 16'hFFFF, 16'd0);
    send_sides(16'd1, 16'd1, 16'd1);
    send_sides(16'd1, 16'd1, 16'd2);
    send_sides(16'd2, 16'd1, 16'd1);
    send_sides(16'd1, 16'd2, 16'd1);
    send_sides(16'd3, 16'd4, 16'd5);
    send_sides(16'h0300, 16'h0400, 16'h0500);
    send_sides(16'h0200, 16'h0200, 16'h0300);
    send_sides(16'h0100, 16'h0100, 16'h0100);
    send_sides(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sides(16'hFFFF, 16'hFFFF, 16'd1);
    send_sides(16'hFFFF, 16'd1, 16'hFFFF);
    send_sides(16'd1, 16'hFFFF, 16'hFFFF);
    send_sides(16'hFFFF, 16'hFFFE, 16'd1);
    send_sides(16'hFFFF, 16'hFFFE, 16'd2);
    send_sides(16'hFFFF, 16'hFFFE, 16'hFFFD);
    send_sides(16'h7FFF, 16'h8000, 16'hFFFF);
    send_sides(16'h8000, 16'h8000, 16'hFFFF);
    send_sides(16'h5555, 16'hAAAA, 16'hAAAA);

    // Random phases: no idling, sender idling, receiver stalling, then both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) send_random_triangle();
    end

    // Back pressure: the receiver holds off for a long stretch while the sender
    // keeps offering back to back, so the pipeline fills and stalls its input.
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    for (n = 0; n < PRESSURE_ITEMS; n++) send_random_triangle();
    side_if.valid <= 1'b0;

    // Wait for every expected result, then a little longer to catch extras.
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    board.close_out();
    if (board.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
